>>> rtl/core/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/lbcf_pkg.sv
`default_nettype none

package lbcf_pkg;

    // field widths
    localparam int KIND_W    = 2;
    localparam int DELTA_W   = 24;
    localparam int GROUP_W   = 4;
    localparam int IDX_W     = 3;
    localparam int SPEED_W   = 24;
    localparam int TLEN_W    = 12;
    localparam int COLOR_W   = 8;
    localparam int ACC_W     = 25;
    localparam int PHASE_W   = 13;
    localparam int NUM_W     = COLOR_W + TLEN_W;
    localparam int CHAN_N    = 3;
    localparam int CHAN_IW   = 2;
    localparam int STEP_W    = 3;

    // apb
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_SPEED   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TLEN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RED_A   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_A = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_A  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RED_B   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_B = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_B  = 3'd7;

    // register reset values
    localparam logic [SPEED_W-1:0] SPEED_RST  = 24'd6554;
    localparam logic [TLEN_W-1:0]  TLEN_RST   = 12'd32;
    localparam logic [COLOR_W-1:0] COLOR_A_RST = 8'd255;
    localparam logic [COLOR_W-1:0] COLOR_B_RST = 8'd0;

    // channel select during the multiply pass
    localparam logic [CHAN_IW-1:0] CHAN_RED   = 2'd0;
    localparam logic [CHAN_IW-1:0] CHAN_GREEN = 2'd1;

    // step counter end values
    localparam logic [STEP_W-1:0] STEP_MUL_LAST = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DIV_LAST = 3'd7;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [TLEN_W-1:0]  tlen;
        logic [COLOR_W-1:0] red_a;
        logic [COLOR_W-1:0] green_a;
        logic [COLOR_W-1:0] blue_a;
        logic [COLOR_W-1:0] red_b;
        logic [COLOR_W-1:0] green_b;
        logic [COLOR_W-1:0] blue_b;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CMP,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic latch_set;
        logic latch_clr;
        logic acc_add;
        logic acc_clr;
        logic phase_step;
        logic mul_step;
        logic div_step;
        logic beat_load;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              player;
        logic              latch;
        logic              acc_gt;
        logic              mul_done;
        logic              div_done;
        logic              beat_last;
        logic              out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/lbcf_regs.sv
`default_nettype none

module lbcf_regs import lbcf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed   <= SPEED_RST;
            r_cfg.tlen    <= TLEN_RST;
            r_cfg.red_a   <= COLOR_A_RST;
            r_cfg.green_a <= COLOR_A_RST;
            r_cfg.blue_a  <= COLOR_A_RST;
            r_cfg.red_b   <= COLOR_B_RST;
            r_cfg.green_b <= COLOR_B_RST;
            r_cfg.blue_b  <= COLOR_B_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SPEED:   r_cfg.speed   <= pwdata[SPEED_W-1:0];
                REG_TLEN:    r_cfg.tlen    <= pwdata[TLEN_W-1:0];
                REG_RED_A:   r_cfg.red_a   <= pwdata[COLOR_W-1:0];
                REG_GREEN_A: r_cfg.green_a <= pwdata[COLOR_W-1:0];
                REG_BLUE_A:  r_cfg.blue_a  <= pwdata[COLOR_W-1:0];
                REG_RED_B:   r_cfg.red_b   <= pwdata[COLOR_W-1:0];
                REG_GREEN_B: r_cfg.green_b <= pwdata[COLOR_W-1:0];
                REG_BLUE_B:  r_cfg.blue_b  <= pwdata[COLOR_W-1:0];
                default:     r_cfg.speed   <= r_cfg.speed;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SPEED:   prdata = PDATA_W'(r_cfg.speed);
            REG_TLEN:    prdata = PDATA_W'(r_cfg.tlen);
            REG_RED_A:   prdata = PDATA_W'(r_cfg.red_a);
            REG_GREEN_A: prdata = PDATA_W'(r_cfg.green_a);
            REG_BLUE_A:  prdata = PDATA_W'(r_cfg.blue_a);
            REG_RED_B:   prdata = PDATA_W'(r_cfg.red_b);
            REG_GREEN_B: prdata = PDATA_W'(r_cfg.green_b);
            REG_BLUE_B:  prdata = PDATA_W'(r_cfg.blue_b);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/core/lbcf_ctrl.sv
`default_nettype none

module lbcf_ctrl import lbcf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_IDLE;
                case (i_sts.kind)
                    KIND_BEGIN: o_cmd.latch_set = i_sts.player;
                    KIND_END:   o_cmd.latch_clr = i_sts.player;
                    KIND_TICK: begin
                        if (i_sts.latch) begin
                            o_cmd.acc_add = 1'b1;
                            n_state       = ST_CMP;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_CMP: begin
                if (i_sts.acc_gt) begin
                    o_cmd.acc_clr    = 1'b1;
                    o_cmd.phase_step = 1'b1;
                    n_state          = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.beat_load = 1'b1;
                    if (i_sts.beat_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/lbcf_dp.sv
`default_nettype none

module lbcf_dp import lbcf_pkg::*; #(
    parameter int LIGHT_COUNT = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire t_cfg               i_cfg,
    output t_sts                    o_sts,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic               i_is_player,
    input  wire logic [DELTA_W-1:0] i_delta_time,
    input  wire logic [GROUP_W-1:0] i_light_group,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [GROUP_W-1:0] o_group_out,
    output logic      [IDX_W-1:0]   o_light_index,
    output logic      [COLOR_W-1:0] o_red_out,
    output logic      [COLOR_W-1:0] o_green_out,
    output logic      [COLOR_W-1:0] o_blue_out,
    output logic                    o_last
);

    localparam int CW = (LIGHT_COUNT > 1) ? $clog2(LIGHT_COUNT) : 1;
    localparam int IW = CW + 1;
    localparam logic [CW-1:0] BEAT_LAST = CW'(LIGHT_COUNT - 1);

    // captured item
    logic [KIND_W-1:0]  r_kind;
    logic               r_player;
    logic [DELTA_W-1:0] r_delta;
    logic [GROUP_W-1:0] r_group;

    // engine state
    logic               r_latch;
    logic [ACC_W-1:0]   r_acc;
    logic [PHASE_W-1:0] r_phase;
    logic [TLEN_W-1:0]  r_tlen;
    logic [TLEN_W-1:0]  r_k;
    logic [STEP_W-1:0]  r_step;
    logic [CW-1:0]      r_beat;

    // divider lanes, one per color channel
    logic [TLEN_W-1:0]  r_rem [CHAN_N];
    logic [COLOR_W-1:0] r_quo [CHAN_N];

    // output beat register
    logic               r_out_valid;
    logic [GROUP_W-1:0] r_out_group;
    logic [IDX_W-1:0]   r_out_idx;
    logic [COLOR_W-1:0] r_out_red;
    logic [COLOR_W-1:0] r_out_green;
    logic [COLOR_W-1:0] r_out_blue;
    logic               r_out_last;

    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   n_acc;
    logic [TLEN_W-1:0]  tlen_eff;
    logic [PHASE_W-1:0] two_t;
    logic [TLEN_W-1:0]  n_k;
    logic [PHASE_W-1:0] phase_inc;
    logic [PHASE_W-1:0] n_phase;
    logic [COLOR_W-1:0] mul_a;
    logic [COLOR_W-1:0] mul_b;
    logic [TLEN_W-1:0]  inv_k;
    logic [NUM_W-1:0]   prod_a;
    logic [NUM_W-1:0]   prod_b;
    logic [NUM_W-1:0]   num;
    logic [TLEN_W:0]    div_tmp  [CHAN_N];
    logic [TLEN_W:0]    div_diff [CHAN_N];
    logic               div_ge   [CHAN_N];
    logic [IW-1:0]      beat_idx;
    logic               out_free;

    // saturating accumulate
    assign acc_sum = {1'b0, r_acc} + {2'b0, r_delta};
    assign n_acc   = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

    // triangle level and next phase; zero length acts as one
    assign tlen_eff  = (i_cfg.tlen == '0) ? TLEN_W'(1) : i_cfg.tlen;
    assign two_t     = {tlen_eff, 1'b0};
    assign phase_inc = r_phase + PHASE_W'(1);
    assign n_phase   = (phase_inc > two_t) ? '0 : phase_inc;

    always_comb begin
        if ({1'b0, tlen_eff} > r_phase) begin
            n_k = r_phase[TLEN_W-1:0];
        end else if (r_phase <= two_t) begin
            n_k = TLEN_W'(two_t - r_phase);
        end else begin
            n_k = '0;
        end
    end

    // numerator a*k + b*(t-k), one channel per cycle
    always_comb begin
        case (r_step[CHAN_IW-1:0])
            CHAN_RED: begin
                mul_a = i_cfg.red_a;
                mul_b = i_cfg.red_b;
            end
            CHAN_GREEN: begin
                mul_a = i_cfg.green_a;
                mul_b = i_cfg.green_b;
            end
            default: begin
                mul_a = i_cfg.blue_a;
                mul_b = i_cfg.blue_b;
            end
        endcase
    end

    assign inv_k  = r_tlen - r_k;
    assign prod_a = {{TLEN_W{1'b0}}, mul_a} * {{COLOR_W{1'b0}}, r_k};
    assign prod_b = {{TLEN_W{1'b0}}, mul_b} * {{COLOR_W{1'b0}}, inv_k};
    assign num    = prod_a + prod_b;

    // restoring divide step, numerator stays below 256*t
    always_comb begin
        for (int c = 0; c < CHAN_N; c++) begin
            div_tmp[c]  = {r_rem[c], r_quo[c][COLOR_W-1]};
            div_diff[c] = div_tmp[c] - {1'b0, r_tlen};
            div_ge[c]   = div_tmp[c] >= {1'b0, r_tlen};
        end
    end

    assign beat_idx = IW'(r_beat) + IW'(1);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_player <= i_is_player;
            r_delta  <= i_delta_time;
            r_group  <= i_light_group;
        end
        if (i_cmd.phase_step) begin
            r_tlen <= tlen_eff;
            r_k    <= n_k;
        end
        if (i_cmd.mul_step) begin
            r_rem[r_step[CHAN_IW-1:0]] <= num[NUM_W-1:COLOR_W];
            r_quo[r_step[CHAN_IW-1:0]] <= num[COLOR_W-1:0];
        end
        if (i_cmd.div_step) begin
            for (int c = 0; c < CHAN_N; c++) begin
                r_rem[c] <= div_ge[c] ? div_diff[c][TLEN_W-1:0] : div_tmp[c][TLEN_W-1:0];
                r_quo[c] <= {r_quo[c][COLOR_W-2:0], div_ge[c]};
            end
        end
        if (i_cmd.beat_load) begin
            r_out_group <= r_group;
            r_out_idx   <= IDX_W'(beat_idx);
            r_out_red   <= r_quo[0];
            r_out_green <= r_quo[1];
            r_out_blue  <= r_quo[2];
            r_out_last  <= (r_beat == BEAT_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch     <= 1'b0;
            r_acc       <= '0;
            r_phase     <= '0;
            r_step      <= '0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.latch_set) begin
                r_latch <= 1'b1;
            end else if (i_cmd.latch_clr) begin
                r_latch <= 1'b0;
            end
            if (i_cmd.acc_clr) begin
                r_acc <= '0;
            end else if (i_cmd.acc_add) begin
                r_acc <= n_acc;
            end
            if (i_cmd.phase_step) begin
                r_phase <= n_phase;
                r_step  <= '0;
                r_beat  <= '0;
            end else if (i_cmd.mul_step && (r_step == STEP_MUL_LAST)) begin
                r_step <= '0;
            end else if (i_cmd.mul_step || i_cmd.div_step) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (i_cmd.beat_load) begin
                r_out_valid <= 1'b1;
                r_beat      <= r_beat + CW'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.player    = r_player;
    assign o_sts.latch     = r_latch;
    assign o_sts.acc_gt    = r_acc > {1'b0, i_cfg.speed};
    assign o_sts.mul_done  = (r_step == STEP_MUL_LAST);
    assign o_sts.div_done  = (r_step == STEP_DIV_LAST);
    assign o_sts.beat_last = (r_beat == BEAT_LAST);
    assign o_sts.out_free  = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_group_out   = r_out_group;
    assign o_light_index = r_out_idx;
    assign o_red_out     = r_out_red;
    assign o_green_out   = r_out_green;
    assign o_blue_out    = r_out_blue;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

>>> rtl/core/led_breathing_color_fade_top.sv
// led breathing engine with a two-color crossfade
//
// input channel (i_in_valid / o_in_ready): one beat is an event. overlap begin
// or end for the tracked player sets or clears the enable latch; a time tick
// adds its elapsed time to the accumulator while the latch is set
// output channel (o_out_valid / i_out_ready): when the accumulator passes the
// speed divider, the tick yields LIGHT_COUNT beats, lights 1..LIGHT_COUNT of
// the tick's group, all with the same blended color, o_last on the final one
// apb port: eight registers at byte offsets 0x00..0x1c, pready tied high;
// write them only while the block is idle
// timing: one item at a time. an event or a tick with no result goes idle after
// decode, or after compare. a producing tick runs decode, compare, multiply
// (one color channel per cycle) and divide (one quotient bit per cycle on three
// lanes) before the first beat is loaded; then one beat per cycle while the
// output register is free or being drained
// stall: beats sit in a single output register; the controller waits while it
// is full, i_out_ready low; after the final load it takes the next item at once
// reset: synchronous, active low; latch off, accumulator and phase zero,
// registers at their defaults, no beat pending
`default_nettype none
`include "assert_macros.svh"

module led_breathing_color_fade_top import lbcf_pkg::*; #(
    parameter int LIGHT_COUNT = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // apb configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // event beats
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic               i_is_player,
    input  wire logic [DELTA_W-1:0] i_delta_time,
    input  wire logic [GROUP_W-1:0] i_light_group,
    // light beats
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [GROUP_W-1:0] o_group_out,
    output logic      [IDX_W-1:0]   o_light_index,
    output logic      [COLOR_W-1:0] o_red_out,
    output logic      [COLOR_W-1:0] o_green_out,
    output logic      [COLOR_W-1:0] o_blue_out,
    output logic                    o_last
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // configuration registers
    lbcf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: decode, compare, multiply, divide, emit
    lbcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // accumulator, phase, blend arithmetic and output register
    lbcf_dp #(
        .LIGHT_COUNT (LIGHT_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_is_player   (i_is_player),
        .i_delta_time  (i_delta_time),
        .i_light_group (i_light_group),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_group_out   (o_group_out),
        .o_light_index (o_light_index),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_last        (o_last)
    );

    // a beat is only loaded when the output register is free or being drained
    `ASSERT_SAME(a_load_when_free, i_clk, i_rst_n, cmd.beat_load, sts.out_free)
    // no beat is loaded while the block takes a new item
    `ASSERT_SAME(a_no_load_idle, i_clk, i_rst_n, o_in_ready, !cmd.beat_load)
    // an accepted item always occupies the block for the following cycle
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

`default_nettype wire

>>> sim/led_breathing_color_fade_top_test.sv
`default_nettype none

module led_breathing_color_fade_top_test;
    import lbcf_pkg::*;

    localparam int LIGHTS = 6;
    // kind code the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned ACC_TOP = (1 << ACC_W) - 1;
    localparam int unsigned PHASE_TOP = (1 << PHASE_W) - 1;
    // quiet cycles after the last beat, covers a non-producing item in flight
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_OFF_CYCLES = 300;

    // one light beat as seen on the output channel
    typedef struct packed {
        logic [GROUP_W-1:0] grp;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               lst;
    } t_light_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [KIND_W-1:0]  i_kind;
    logic               i_is_player;
    logic [DELTA_W-1:0] i_delta_time;
    logic [GROUP_W-1:0] i_light_group;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [GROUP_W-1:0] o_group_out;
    logic [IDX_W-1:0]   o_light_index;
    logic [COLOR_W-1:0] o_red_out;
    logic [COLOR_W-1:0] o_green_out;
    logic [COLOR_W-1:0] o_blue_out;
    logic               o_last;

    led_breathing_color_fade_top #(
        .LIGHT_COUNT(LIGHTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_is_player  (i_is_player),
        .i_delta_time (i_delta_time),
        .i_light_group(i_light_group),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_group_out  (o_group_out),
        .o_light_index(o_light_index),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_last       (o_last)
    );

    // shadow of the breathing engine: registers, latch, accumulator, phase
    logic [PDATA_W-1:0] reg_shadow [8];
    logic               fade_on;
    logic [ACC_W-1:0]   elapsed_acc;
    logic [PHASE_W-1:0] phase_pos;

    // light beats still owed by the block, oldest first
    t_light_beat        light_q [$];

    int err_count;
    int idle_pct;
    int stall_pct;
    int hold_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off counted down here
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_out_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [PDATA_W-1:0] reg_mask(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_SPEED: return 32'h00FF_FFFF;
            REG_TLEN:  return 32'h0000_0FFF;
            default:   return 32'h0000_00FF;
        endcase
    endfunction

    // integer crossfade between peak color a and trough color b
    function automatic logic [COLOR_W-1:0] crossfade(input int unsigned a, input int unsigned b,
                                                     input int unsigned k, input int unsigned t);
        return COLOR_W'((a * k + b * (t - k)) / t);
    endfunction

    function automatic void note_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        if (err_count < MAX_REPORTS)
            $display("mismatch %s: expected %0d actual %0d", what, want, got);
        err_count = err_count + 1;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
            note_mismatch(what, want, got);
    endfunction

    // advance the shadow on one accepted event and queue the beats it owes
    task automatic predict_event(input logic [KIND_W-1:0] kind, input logic player,
                                 input logic [DELTA_W-1:0] delta,
                                 input logic [GROUP_W-1:0] grp);
        int unsigned sum;
        int unsigned t;
        int unsigned p;
        int unsigned k;
        int n;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        t_light_beat bt;
        case (kind)
            KIND_BEGIN: begin
                if (player)
                    fade_on = 1'b1;
            end
            KIND_END: begin
                if (player)
                    fade_on = 1'b0;
            end
            KIND_TICK: begin
                if (fade_on) begin
                    sum = elapsed_acc + delta;
                    // accumulator saturates
                    if (sum > ACC_TOP)
                        sum = ACC_TOP;
                    if (sum <= reg_shadow[REG_SPEED]) begin
                        elapsed_acc = ACC_W'(sum);
                    end else begin
                        elapsed_acc = '0;
                        // zero length behaves as one
                        t = reg_shadow[REG_TLEN];
                        if (t == 0)
                            t = 1;
                        p = phase_pos;
                        // triangle level, zero when a shorter length left the phase past the end
                        if (p < t)
                            k = p;
                        else if (p <= 2 * t)
                            k = 2 * t - p;
                        else
                            k = 0;
                        p = (p + 1) & PHASE_TOP;
                        if (p > 2 * t)
                            p = 0;
                        phase_pos = PHASE_W'(p);
                        r = crossfade(reg_shadow[REG_RED_A], reg_shadow[REG_RED_B], k, t);
                        g = crossfade(reg_shadow[REG_GREEN_A], reg_shadow[REG_GREEN_B], k, t);
                        b = crossfade(reg_shadow[REG_BLUE_A], reg_shadow[REG_BLUE_B], k, t);
                        for (n = 1; n <= LIGHTS; n++) begin
                            bt.grp   = grp;
                            bt.idx   = IDX_W'(n);
                            bt.red   = r;
                            bt.green = g;
                            bt.blue  = b;
                            bt.lst   = (n == LIGHTS);
                            light_q.push_back(bt);
                        end
                    end
                end
            end
            default: ;  // unused kind leaves everything alone
        endcase
    endtask

    // output checker: each beat against the oldest owed beat
    always @(posedge i_clk) begin : beat_check
        t_light_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (light_q.size() == 0) begin
                note_mismatch("unexpected beat, light index", 0, o_light_index);
            end else begin
                want = light_q.pop_front();
                check_field("group", want.grp, o_group_out);
                check_field("light index", want.idx, o_light_index);
                check_field("red", want.red, o_red_out);
                check_field("green", want.green, o_green_out);
                check_field("blue", want.blue, o_blue_out);
                check_field("last", want.lst, o_last);
            end
        end
    end

    // apb write; upper bits beyond the register width carry junk
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        logic [PDATA_W-1:0] word;
        word = ($urandom() & ~reg_mask(idx)) | (value & reg_mask(idx));
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        reg_shadow[idx] = word & reg_mask(idx);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // apb read, compared with the shadow
    task automatic apb_read(input logic [REG_IDX_W-1:0] idx);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = PADDR_W'({idx, 2'b00});
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("register read", reg_shadow[idx], prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // full register load with read-back; only called once the block is idle
    task automatic load_settings(input int unsigned speed, input int unsigned tlen,
                                 input int unsigned ra, input int unsigned ga,
                                 input int unsigned ba, input int unsigned rb,
                                 input int unsigned gb, input int unsigned bb);
        apb_write(REG_SPEED, speed);
        apb_write(REG_TLEN, tlen);
        apb_write(REG_RED_A, ra);
        apb_write(REG_GREEN_A, ga);
        apb_write(REG_BLUE_A, ba);
        apb_write(REG_RED_B, rb);
        apb_write(REG_GREEN_B, gb);
        apb_write(REG_BLUE_B, bb);
        apb_read(REG_SPEED);
        apb_read(REG_TLEN);
        apb_read(REG_RED_A);
        apb_read(REG_GREEN_A);
        apb_read(REG_BLUE_A);
        apb_read(REG_RED_B);
        apb_read(REG_GREEN_B);
        apb_read(REG_BLUE_B);
    endtask

    // offer one event beat; returns at the edge that accepts it, valid still high
    task automatic send_event(input logic [KIND_W-1:0] kind, input logic player,
                              input logic [DELTA_W-1:0] delta,
                              input logic [GROUP_W-1:0] grp);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_kind        = kind;
        i_is_player   = player;
        i_delta_time  = delta;
        i_light_group = grp;
        do @(posedge i_clk); while (!o_in_ready);
        predict_event(kind, player, delta, grp);
    endtask

    // stop offering, wait for every owed beat, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (light_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // latch handling and every kind, at the reset register values
    task automatic test_latch_and_kinds();
        // latch off: a tick does nothing
        send_event(KIND_TICK, 1'b1, 24'hFF_FFFF, 4'd15);
        // begin for someone else leaves the latch off
        send_event(KIND_BEGIN, 1'b0, 24'h00_0000, 4'd0);
        send_event(KIND_TICK, 1'b0, 24'hFF_FFFF, 4'd3);
        // unused kind, even with the player flag set
        send_event(KIND_UNUSED, 1'b1, 24'hFF_FFFF, 4'd15);
        send_event(KIND_TICK, 1'b1, 24'hFF_FFFF, 4'd15);
        send_event(KIND_BEGIN, 1'b1, 24'h00_0000, 4'd0);
        // zero delta, then exactly the divider: no step yet
        send_event(KIND_TICK, 1'b0, 24'h00_0000, 4'd0);
        send_event(KIND_TICK, 1'b0, 24'd6554, 4'd0);
        send_event(KIND_TICK, 1'b1, 24'd1, 4'd0);
        send_event(KIND_TICK, 1'b0, 24'hFF_FFFF, 4'd15);
        // end for someone else keeps it running
        send_event(KIND_END, 1'b0, 24'hFF_FFFF, 4'd15);
        send_event(KIND_TICK, 1'b1, 24'hAA_AAAA, 4'd10);
        send_event(KIND_TICK, 1'b0, 24'h55_5555, 4'd5);
        send_event(KIND_END, 1'b1, 24'h00_0000, 4'd0);
        send_event(KIND_TICK, 1'b0, 24'hFF_FFFF, 4'd15);
        send_event(KIND_BEGIN, 1'b1, 24'h00_0000, 4'd0);
        settle();
    endtask

    // zero transition length acts as one; colors swapped to the other extremes
    task automatic test_zero_length();
        int n;
        load_settings(0, 0, 0, 0, 0, 255, 255, 255);
        // zero delta never passes a zero divider
        send_event(KIND_TICK, 1'b0, 24'h00_0000, 4'd7);
        for (n = 0; n < 5; n++)
            send_event(KIND_TICK, 1'b0, 24'd1, 4'(n));
        settle();
    endtask

    // phase left past the end of a shorter triangle
    task automatic test_phase_overrun();
        int n;
        load_settings(0, 40, 200, 100, 50, 10, 20, 30);
        for (n = 0; n < 12; n++)
            send_event(KIND_TICK, 1'b0, 24'd3, 4'd9);
        settle();
        load_settings(0, 2, 255, 0, 128, 0, 255, 64);
        for (n = 0; n < 4; n++)
            send_event(KIND_TICK, 1'b0, 24'd3, 4'd12);
        settle();
    endtask

    // largest divider and deltas, near the accumulator top
    task automatic test_wide_accumulate();
        load_settings(24'hFF_FFFF, 4095, 255, 255, 255, 0, 0, 0);
        send_event(KIND_TICK, 1'b0, 24'hFF_FFFF, 4'd1);
        send_event(KIND_TICK, 1'b0, 24'hFF_FFFF, 4'd2);
        send_event(KIND_TICK, 1'b0, 24'hFF_FFFE, 4'd3);
        send_event(KIND_TICK, 1'b0, 24'd1, 4'd4);
        send_event(KIND_TICK, 1'b0, 24'hFF_FFFF, 4'd5);
        settle();
    endtask

    // receiver holds off long while ticks keep coming: the block must stall its input
    task automatic test_backpressure();
        int n;
        load_settings(0, 7, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255));
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        for (n = 0; n < 15; n++)
            send_event(KIND_TICK, 1'b0, 24'($urandom_range(1, 1000)), 4'($urandom_range(15)));
        settle();
    endtask

    // random settings, then mostly well-formed breathing traffic with some noise
    task automatic run_random_phase(input int idle, input int stall, input int items);
        int useful;
        int pick;
        int unsigned speed;
        int unsigned tlen;
        logic [KIND_W-1:0]  kind;
        logic               player;
        logic [DELTA_W-1:0] delta;
        case ($urandom_range(3))
            0:       speed = 0;
            1:       speed = $urandom_range(1, 64);
            2:       speed = $urandom_range(65, 4000);
            default: speed = 24'hFF_FFFF;
        endcase
        case ($urandom_range(3))
            0:       tlen = 1;
            1:       tlen = 4095;
            2:       tlen = $urandom_range(0, 16);
            default: tlen = $urandom_range(0, 4095);
        endcase
        load_settings(speed, tlen, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255));
        idle_pct  = idle;
        stall_pct = stall;
        useful    = 0;
        while (useful < items) begin
            pick   = $urandom_range(99);
            kind   = KIND_TICK;
            player = 1'($urandom_range(1));
            if (speed > 4000 || $urandom_range(7) == 0)
                delta = DELTA_W'($urandom());
            else
                delta = 24'($urandom_range(0, 2 * speed + 1));
            if (!fade_on && pick < 70) begin
                kind   = KIND_BEGIN;
                player = ($urandom_range(3) != 0);
            end else if (fade_on && pick < 4) begin
                kind = KIND_BEGIN;
            end else if (pick < 8) begin
                kind = KIND_END;
            end else if (pick < 11) begin
                kind = KIND_UNUSED;
            end
            // ticks with the latch off and unused kinds do not count toward the item total
            if ((kind == KIND_TICK && fade_on) || kind == KIND_BEGIN || kind == KIND_END)
                useful = useful + 1;
            send_event(kind, player, delta, 4'($urandom_range(15)));
        end
        settle();
    endtask

    initial begin
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_TICK;
        i_is_player   = 1'b0;
        i_delta_time  = '0;
        i_light_group = '0;
        i_rst_n       = 1'b0;
        err_count     = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_left     = 0;
        // shadow starts at the reset values
        reg_shadow[REG_SPEED]   = SPEED_RST;
        reg_shadow[REG_TLEN]    = TLEN_RST;
        reg_shadow[REG_RED_A]   = COLOR_A_RST;
        reg_shadow[REG_GREEN_A] = COLOR_A_RST;
        reg_shadow[REG_BLUE_A]  = COLOR_A_RST;
        reg_shadow[REG_RED_B]   = COLOR_B_RST;
        reg_shadow[REG_GREEN_B] = COLOR_B_RST;
        reg_shadow[REG_BLUE_B]  = COLOR_B_RST;
        fade_on     = 1'b0;
        elapsed_acc = '0;
        phase_pos   = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_latch_and_kinds();
        test_zero_length();
        test_phase_overrun();
        test_wide_accumulate();
        test_backpressure();
        run_random_phase(0, 0, 60);
        run_random_phase(58, 0, 60);
        run_random_phase(0, 58, 60);
        run_random_phase(31, 31, 60);

        // anything still owed counts against the run
        err_count = err_count + light_q.size();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
